// ----- sv/mfas_pkg.sv -----
// ----------------------------------------------------------------------------
// mfas_pkg: shared types and constants for most-fractional cell selection
// Fixed-point formats, request/result payloads, register indexes, states.
// ----------------------------------------------------------------------------
`default_nettype none

package mfas_pkg;

  // Fixed-point format: unsigned Q4.16
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SUM_W     = FRAC_BITS + 4;
  localparam int unsigned LP_W      = FRAC_BITS + 1;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned EPS_W     = 16;
  localparam int unsigned NZ_W      = 4;

  localparam logic [LP_W-1:0]  ONE_VAL  = LP_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF_VAL = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] SUM_TOP  = {SUM_W{1'b1}};
  localparam logic [NZ_W-1:0]  NZ_TOP   = {NZ_W{1'b1}};

  // Field widths of the payloads
  localparam int unsigned CUST_W  = 8;
  localparam int unsigned DAY_W   = 3;
  localparam int unsigned CCNT_W  = 9;
  localparam int unsigned DCNT_W  = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOMER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_EPSILON    = 2'd3;

  localparam logic [CCNT_W-1:0] CUSTOMER_COUNT_RST = 9'd256;
  localparam logic [DCNT_W-1:0] DAY_COUNT_RST      = 4'd8;

  // Request kinds
  localparam logic REQ_ACCUMULATE = 1'b0;
  localparam logic REQ_SELECT     = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CUST_W-1:0] customer;
    logic [DAY_W-1:0]  day;
    logic [LP_W-1:0]   lp_value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [CUST_W-1:0] best_customer;
    logic [DAY_W-1:0]  chosen_day;
    logic [DIST_W-1:0] best_distance;
    logic              saturated;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ----- sv/most_fractional_assignment_select.sv -----
// ----------------------------------------------------------------------------
// most_fractional_assignment_select: most-fractional customer-day selection
// Accumulates fractional LP values per customer-day cell and picks the cell
// closest to one half, ties toward customers with more nonzero days.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | in_valid_i / in_stall_o    | in_data_i  (req_t)
//  out     | output    | out_valid_o / out_stall_i  | out_data_o (rsp_t)
//  cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// An accumulate request reads the cell and day-count memories, then writes
// both back in ST_UPDATE. A select request runs a scan that reads every cell
// once while zeroing it. After reset a clearing pass zeroes both memories
// with in_stall_o high. The result sits in an output register, so accumulate
// requests are taken while it waits on out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module most_fractional_assignment_select #(
  parameter int unsigned MAX_CUSTOMERS = 256,
  parameter int unsigned MAX_DAYS      = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mfas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mfas_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire mfas_pkg::req_t                     in_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      mfas_pkg::rsp_t                     out_data_o
);

  import mfas_pkg::*;

  localparam int unsigned DEPTH = MAX_CUSTOMERS * MAX_DAYS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_CUSTOMERS);
  localparam int unsigned DW    = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;

  // Configuration registers
  logic [CCNT_W-1:0] cust_cnt_q;
  logic [DCNT_W-1:0] day_cnt_q;
  logic [EPS_W-1:0]  eps_q;
  logic [EPS_W-1:0]  sum_eps_q;

  // Control state
  state_e          state_q, state_d;
  logic            report_q, report_d;
  logic [AW-1:0]   scan_addr_q, scan_addr_d;
  logic [CW-1:0]   scan_cust_q, scan_cust_d;
  logic [DW-1:0]   scan_day_q, scan_day_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   rd_addr_q;
  logic [CW-1:0]   rd_cust_q;
  logic [DW-1:0]   rd_day_q;
  logic            sat_q, sat_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  // Accumulate request registers
  logic            upd_ok_q;
  logic [AW-1:0]   upd_addr_q;
  logic [CW-1:0]   upd_cust_q;
  logic [LP_W-1:0] upd_lp_q;

  // Running best of the scan
  logic             found_q, found_d;
  logic [SUM_W-1:0] best_q, best_d;
  logic [NZ_W-1:0]  best_nz_q, best_nz_d;
  logic [CW-1:0]    best_cust_q, best_cust_d;
  logic [DW-1:0]    lead_day_q, lead_day_d;

  // Memory ports
  logic             cell_we, nz_we;
  logic [AW-1:0]    cell_waddr, cell_raddr;
  logic [SUM_W-1:0] cell_wdata, cell_rdata;
  logic [CW-1:0]    nz_waddr, nz_raddr;
  logic [NZ_W-1:0]  nz_wdata, nz_rdata;

  logic             in_accept;
  logic             req_frac, req_in_range;
  logic [AW-1:0]    req_addr;
  logic             scan_last;

  // Update datapath
  logic [SUM_W:0]   upd_sum;
  logic             upd_sat;
  logic [NZ_W-1:0]  upd_nz;

  // Scan datapath
  logic [SUM_W-1:0] cur_dist, dist_half, dist_best;
  logic             cell_used, skip_int, skip_far, skip_tie, take;

  mfas_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_waddr),
    .wdata_i(cell_wdata),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  mfas_ram #(.WIDTH(NZ_W), .DEPTH(MAX_CUSTOMERS)) u_nz_ram (
    .clk_i  (clk_i),
    .we_i   (nz_we),
    .waddr_i(nz_waddr),
    .wdata_i(nz_wdata),
    .raddr_i(nz_raddr),
    .rdata_o(nz_rdata)
  );

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cust_cnt_q <= CUSTOMER_COUNT_RST;
      day_cnt_q  <= DAY_COUNT_RST;
      eps_q      <= '0;
      sum_eps_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CUSTOMER_COUNT: cust_cnt_q <= cfg_data_i[CCNT_W-1:0];
        CFG_DAY_COUNT:      day_cnt_q  <= cfg_data_i[DCNT_W-1:0];
        CFG_EPSILON:        eps_q      <= cfg_data_i[EPS_W-1:0];
        CFG_SUM_EPSILON:    sum_eps_q  <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the incoming request
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign req_frac = (LP_W'(sum_eps_q) < in_data_i.lp_value) &&
                    (in_data_i.lp_value < ONE_VAL) &&
                    (LP_W'(sum_eps_q) < (ONE_VAL - in_data_i.lp_value));
  assign req_in_range = (32'(in_data_i.customer) < 32'(cust_cnt_q)) &&
                        (32'(in_data_i.customer) < 32'(MAX_CUSTOMERS)) &&
                        (32'(in_data_i.day) < 32'(day_cnt_q)) &&
                        (32'(in_data_i.day) < 32'(MAX_DAYS));
  assign req_addr = AW'(AW'(in_data_i.customer) * AW'(MAX_DAYS) + AW'(in_data_i.day));

  // Hold the accumulate request for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      upd_addr_q <= req_addr;
      upd_cust_q <= CW'(in_data_i.customer);
      upd_lp_q   <= in_data_i.lp_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_ok_q <= 1'b0;
    end else if (in_accept) begin
      upd_ok_q <= (in_data_i.req_type == REQ_ACCUMULATE) && req_frac && req_in_range;
    end
  end

  // Read address: scan counters while scanning, else the incoming request
  assign cell_raddr = (state_q == ST_SCAN) ? scan_addr_q : req_addr;
  assign nz_raddr   = (state_q == ST_SCAN) ? scan_cust_q : CW'(in_data_i.customer);

  // Read-modify-write of one cell
  assign upd_sum = {1'b0, cell_rdata} + (SUM_W + 1)'(upd_lp_q);
  assign upd_sat = (upd_sum > {1'b0, SUM_TOP});
  assign upd_nz  = ((cell_rdata <= SUM_W'(eps_q)) && (nz_rdata != NZ_TOP)) ?
                   nz_rdata + NZ_W'(1) : nz_rdata;

  // Scan evaluation of the cell read last cycle
  always_comb begin
    cur_dist  = (cell_rdata >= HALF_VAL) ? cell_rdata - HALF_VAL : HALF_VAL - cell_rdata;
    dist_half = (cur_dist >= HALF_VAL) ? cur_dist - HALF_VAL : HALF_VAL - cur_dist;
    dist_best = (cur_dist >= best_q) ? cur_dist - best_q : best_q - cur_dist;
    cell_used = (32'(rd_cust_q) < 32'(cust_cnt_q)) && (32'(rd_day_q) < 32'(day_cnt_q));
    skip_int  = (dist_half <= SUM_W'(eps_q));
    skip_far  = (cur_dist > best_q) && (dist_best > SUM_W'(eps_q));
    skip_tie  = (dist_best <= SUM_W'(eps_q)) && (nz_rdata <= best_nz_q);
    take      = report_q && rd_vld_q && cell_used && !skip_int && !skip_far && !skip_tie;
  end

  // Memory write ports: write-back on update, zero behind the scan
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = rd_addr_q;
    cell_wdata = '0;
    nz_we      = 1'b0;
    nz_waddr   = rd_cust_q;
    nz_wdata   = '0;
    if (state_q == ST_UPDATE) begin
      cell_we    = upd_ok_q;
      cell_waddr = upd_addr_q;
      cell_wdata = upd_sat ? SUM_TOP : upd_sum[SUM_W-1:0];
      nz_we      = upd_ok_q;
      nz_waddr   = upd_cust_q;
      nz_wdata   = upd_nz;
    end else if (rd_vld_q) begin
      cell_we = 1'b1;
      nz_we   = (rd_day_q == DW'(MAX_DAYS - 1));
    end
  end

  assign scan_last = (scan_cust_q == CW'(MAX_CUSTOMERS - 1)) &&
                     (scan_day_q == DW'(MAX_DAYS - 1));

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    report_d    = report_q;
    scan_addr_d = scan_addr_q;
    scan_cust_d = scan_cust_q;
    scan_day_d  = scan_day_q;
    rd_vld_d    = 1'b0;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    found_d     = found_q;
    best_d      = best_q;
    best_nz_d   = best_nz_q;
    best_cust_d = best_cust_q;
    lead_day_d  = lead_day_q;

    // Track the best cell during the scan
    if (take) begin
      found_d     = 1'b1;
      best_d      = cur_dist;
      best_nz_d   = nz_rdata;
      best_cust_d = rd_cust_q;
      lead_day_d  = rd_day_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.req_type == REQ_SELECT) begin
            state_d     = ST_SCAN;
            report_d    = 1'b1;
            scan_addr_d = '0;
            scan_cust_d = '0;
            scan_day_d  = '0;
            found_d     = 1'b0;
            best_d      = HALF_VAL;
            best_nz_d   = '0;
            best_cust_d = '0;
            lead_day_d  = '0;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (upd_ok_q && upd_sat) begin
          sat_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        rd_vld_d    = 1'b1;
        scan_addr_d = scan_addr_q + AW'(1);
        if (scan_day_q == DW'(MAX_DAYS - 1)) begin
          scan_day_d  = '0;
          scan_cust_d = scan_cust_q + CW'(1);
        end else begin
          scan_day_d = scan_day_q + DW'(1);
        end
        if (scan_last) begin
          scan_addr_d = '0;
          scan_cust_d = '0;
          scan_day_d  = '0;
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = report_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_d.found             = found_q;
          out_d.best_customer     = found_q ? CUST_W'(best_cust_q) : '0;
          out_d.chosen_day        = found_q ? DAY_W'(lead_day_q) : '0;
          out_d.best_distance     = found_q ? best_q[DIST_W-1:0] : '0;
          out_d.saturated         = sat_q;
          sat_d                   = 1'b0;
          report_d                = 1'b0;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SCAN;
      report_q    <= 1'b0;
      scan_addr_q <= '0;
      scan_cust_q <= '0;
      scan_day_q  <= '0;
      rd_vld_q    <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      report_q    <= report_d;
      scan_addr_q <= scan_addr_d;
      scan_cust_q <= scan_cust_d;
      scan_day_q  <= scan_day_d;
      rd_vld_q    <= rd_vld_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q   <= scan_addr_q;
    rd_cust_q   <= scan_cust_q;
    rd_day_q    <= scan_day_q;
    out_q       <= out_d;
    best_q      <= best_d;
    best_nz_q   <= best_nz_d;
    best_cust_q <= best_cust_d;
    lead_day_q  <= lead_day_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/mfas_ram.sv -----
// ----------------------------------------------------------------------------
// mfas_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mfas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- tb/most_fractional_assignment_select_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// most_fractional_assignment_select_tb: self-checking regression
// Sends visit and select requests with random idling on both channels and
// predicts every pick from a local copy of the customer-day store. Each
// result is compared field by field with the oldest predicted pick.
// ----------------------------------------------------------------------------
module most_fractional_assignment_select_tb;
  import mfas_pkg::*;

  localparam int unsigned CUSTOMERS     = 256;
  localparam int unsigned DAYS          = 8;
  localparam int unsigned CELLS         = CUSTOMERS * DAYS;
  localparam int unsigned DAY_CNT_TOP   = 15;
  localparam int unsigned UNIT          = ONE_VAL;
  localparam int unsigned HALF          = HALF_VAL;
  localparam int unsigned SUM_MAX       = SUM_TOP;
  localparam int unsigned HOLD_CYCLES   = 6000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TIMEOUT_NS    = 20000000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_CUSTOMER_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  req_t                  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_data_o;

  // Local copy of the store and of the registers
  int unsigned cell_total [CELLS];
  int unsigned busy_days [CUSTOMERS];
  bit          sat_seen;
  int unsigned cust_limit;
  int unsigned day_limit;
  int unsigned zero_tol;
  int unsigned frac_tol;

  rsp_t        picks_due [$];
  rsp_t        due;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned hold_ticket   = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  most_fractional_assignment_select #(
    .MAX_CUSTOMERS(CUSTOMERS),
    .MAX_DAYS     (DAYS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("most_fractional_assignment_select regression: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic int unsigned gap_of(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int unsigned customers_in_use();
    return (cust_limit > CUSTOMERS) ? CUSTOMERS : cust_limit;
  endfunction

  function automatic int unsigned days_in_use();
    return (day_limit > DAYS) ? DAYS : day_limit;
  endfunction

  function automatic void wipe_store();
    int unsigned k;
    for (k = 0; k < CELLS; k++) cell_total[k] = 0;
    for (k = 0; k < CUSTOMERS; k++) busy_days[k] = 0;
    sat_seen = 1'b0;
  endfunction

  // Add one visit to its cell when the value is strictly fractional
  function automatic void absorb_visit(req_t r);
    int unsigned lp;
    int unsigned slot;
    int unsigned acc;
    lp = r.lp_value;
    if (!(lp > frac_tol && lp < UNIT && UNIT - lp > frac_tol)) return;
    if (r.customer >= customers_in_use() || r.day >= days_in_use()) return;
    slot = r.customer * DAYS + r.day;
    acc = cell_total[slot];
    if (acc <= zero_tol && busy_days[r.customer] < DAY_CNT_TOP) begin
      busy_days[r.customer]++;
    end
    if (lp > SUM_MAX - acc) begin
      acc = SUM_MAX;
      sat_seen = 1'b1;
    end else begin
      acc += lp;
    end
    cell_total[slot] = acc;
  endfunction

  // Find the cell closest to one half, then clear the store
  function automatic rsp_t pick_most_fractional();
    rsp_t        pick;
    int unsigned best;
    int unsigned best_days;
    int unsigned cur;
    int unsigned bc;
    int unsigned bd;
    int unsigned i;
    int unsigned j;
    bit          hit;
    pick = '0;
    best = HALF;
    best_days = 0;
    bc = 0;
    bd = 0;
    hit = 1'b0;
    for (i = 0; i < customers_in_use(); i++) begin
      for (j = 0; j < days_in_use(); j++) begin
        cur = gap_of(HALF, cell_total[i * DAYS + j]);
        // skip cells that sit on an integer
        if (gap_of(cur, HALF) <= zero_tol) continue;
        if (cur > best && cur - best > zero_tol) continue;
        // near-tie: keep the earlier pick unless this customer is busier
        if (gap_of(cur, best) <= zero_tol && busy_days[i] <= best_days) continue;
        hit = 1'b1;
        bc = i;
        bd = j;
        best_days = busy_days[i];
        best = cur;
      end
    end
    pick.found = hit;
    if (hit) begin
      pick.best_customer = bc[CUST_W-1:0];
      pick.chosen_day    = bd[DAY_W-1:0];
      pick.best_distance = best[DIST_W-1:0];
    end
    pick.saturated = sat_seen;
    wipe_store();
    return pick;
  endfunction

  // ------------------------------------------------------------------------
  // Result side: stall at random, hold off on request, check each pick
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_ticket;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (picks_due.size() == 0) begin
        mismatches++;
        $display("%0t: pick expected none actual %h", $time, out_data_o);
      end else begin
        due = picks_due.pop_front();
        compare_field("found", due.found, out_data_o.found);
        compare_field("best_customer", due.best_customer, out_data_o.best_customer);
        compare_field("chosen_day", due.chosen_day, out_data_o.chosen_day);
        compare_field("best_distance", due.best_distance, out_data_o.best_distance);
        compare_field("saturated", due.saturated, out_data_o.saturated);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------
  task automatic send_request(input req_t r);
    int unsigned gap;
    // idle for a while before offering, now and then
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 4) : $urandom_range(3, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (r.req_type == REQ_SELECT) begin
      picks_due.push_back(pick_most_fractional());
    end else begin
      absorb_visit(r);
    end
  endtask

  task automatic send_visit(input int unsigned cust, input int unsigned day,
                            input int unsigned lp);
    req_t r;
    r.req_type = REQ_ACCUMULATE;
    r.customer = cust[CUST_W-1:0];
    r.day      = day[DAY_W-1:0];
    r.lp_value = lp[LP_W-1:0];
    send_request(r);
  endtask

  // Select with random filler in the unused fields
  task automatic send_select();
    logic [31:0] junk;
    req_t        r;
    junk       = $urandom;
    r          = junk[$bits(req_t)-1:0];
    r.req_type = REQ_SELECT;
    send_request(r);
  endtask

  // Drop valid and wait until every pick is back and the block is idle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CUSTOMER_COUNT: cust_limit = value[CCNT_W-1:0];
      CFG_DAY_COUNT:      day_limit  = value[DCNT_W-1:0];
      CFG_EPSILON:        zero_tol   = value[EPS_W-1:0];
      CFG_SUM_EPSILON:    frac_tol   = value[EPS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned cc, input int unsigned dc,
                                input int unsigned eps, input int unsigned seps);
    write_register(CFG_CUSTOMER_COUNT, cc);
    write_register(CFG_DAY_COUNT, dc);
    write_register(CFG_EPSILON, eps);
    write_register(CFG_SUM_EPSILON, seps);
  endtask

  // Mix of grid values, values near one half, edge values and junk
  function automatic int unsigned draw_lp(int unsigned tol);
    int unsigned sel;
    int unsigned edge_val;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom_range(8) * 8192;
    if (sel < 55) return $urandom_range(HALF + 1024, HALF - 1024);
    if (sel < 85) return $urandom_range(UNIT);
    if (sel < 95) begin
      edge_val = (sel[0] ? tol : UNIT - tol) + $urandom_range(3);
      return (edge_val == 0) ? 0 : edge_val - 1;
    end
    return $urandom_range(2 * UNIT - 1, UNIT + 1);
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_empty_select();
    send_select();
    quiesce();
  endtask

  task automatic test_field_extremes();
    send_visit(0, 0, 0);
    send_visit(0, 0, UNIT);
    send_visit(0, 0, 2 * UNIT - 1);
    send_visit(255, 7, UNIT - 1);
    send_visit(0, 0, 1);
    // exact half gives distance zero
    send_visit(1, 3, HALF);
    // two halves make a whole: skipped by the scan
    send_visit(4, 4, HALF);
    send_visit(4, 4, HALF);
    send_select();
    quiesce();
  endtask

  task automatic test_out_of_range_cells();
    apply_settings(2, 2, 0, 1000);
    send_visit(2, 0, 30000);
    send_visit(0, 2, 30000);
    send_visit(1, 1, 1000);
    send_visit(1, 1, UNIT - 1000);
    send_visit(1, 1, 1001);
    send_select();
    quiesce();
  endtask

  task automatic test_zero_counts();
    apply_settings(0, 0, 0, 0);
    send_visit(0, 0, 30000);
    send_select();
    quiesce();
  endtask

  task automatic test_clamped_counts();
    apply_settings(511, 15, 0, 0);
    send_visit(255, 7, 20000);
    send_visit(200, 1, 45000);
    send_select();
    quiesce();
  endtask

  // Hammer one cell past the top, then check the flag clears on select
  task automatic test_saturation();
    int unsigned cust;
    int unsigned day;
    int unsigned reps;
    int unsigned k;
    apply_settings(256, 8, 0, 0);
    cust = $urandom_range(255);
    day  = $urandom_range(7);
    reps = $urandom_range(20, 17);
    for (k = 0; k < reps; k++) send_visit(cust, day, $urandom_range(65535, 62000));
    send_visit((cust + 1) % CUSTOMERS, day, $urandom_range(64000, 1000));
    send_select();
    send_select();
    quiesce();
  endtask

  // Push one customer's day count to its top, then force a near-tie
  task automatic test_day_counter_full();
    int unsigned busy;
    int unsigned calm;
    int unsigned k;
    apply_settings(16, 8, 200, 0);
    busy = $urandom_range(15);
    calm = (busy + 1 + $urandom_range(13)) % 16;
    for (k = 0; k < 18; k++) send_visit(busy, $urandom_range(7), $urandom_range(5, 1));
    send_visit(calm, $urandom_range(7), 30000 + $urandom_range(100));
    send_visit(busy, $urandom_range(7), 30000 + $urandom_range(100));
    send_select();
    quiesce();
  endtask

  // Hold off the result side long enough for the input to stall
  task automatic test_back_pressure();
    int unsigned k;
    apply_settings(8, 4, 100, 50);
    hold_ticket <= hold_ticket + 1;
    for (k = 0; k < 24; k++) begin
      if (k % 8 == 7) begin
        send_select();
      end else begin
        send_visit($urandom_range(7), $urandom_range(3), draw_lp(50));
      end
    end
    quiesce();
  endtask

  // Visits mostly to a small pool of customers so cells build up sums
  task automatic test_random_traffic(input int unsigned n, input int unsigned cc,
                                     input int unsigned dc, input int unsigned eps,
                                     input int unsigned seps);
    int unsigned pool [4];
    int unsigned nc;
    int unsigned nd;
    int unsigned cust;
    int unsigned day;
    int unsigned k;
    apply_settings(cc, dc, eps, seps);
    nc = customers_in_use();
    nd = days_in_use();
    for (k = 0; k < 4; k++) pool[k] = (nc == 0) ? 0 : $urandom_range(nc - 1);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(8) == 0) begin
        send_select();
      end else begin
        cust = ($urandom_range(4) == 0 || nc == 0) ? $urandom_range(255)
                                                    : pool[$urandom_range(3)];
        day  = ($urandom_range(6) == 0 || nd == 0) ? $urandom_range(7)
                                                    : $urandom_range(nd - 1);
        send_visit(cust, day, draw_lp(seps));
      end
    end
    send_select();
    quiesce();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    wipe_store();
    cust_limit = CUSTOMER_COUNT_RST;
    day_limit  = DAY_COUNT_RST;
    zero_tol   = 0;
    frac_tol   = 0;
    send_idle_pct = 32;
    recv_idle_pct = 49;

    // release reset and wait out the clearing pass
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);

    test_empty_select();
    test_field_extremes();
    test_out_of_range_cells();
    test_zero_counts();
    test_clamped_counts();

    test_saturation();
    test_day_counter_full();
    test_random_traffic(70, 4, 3, 0, 0);
    test_random_traffic(70, 16, 8, 2000, 500);

    send_idle_pct = 49;
    recv_idle_pct = 32;
    test_back_pressure();
    test_random_traffic(70, 256, 8, 0, 0);
    test_random_traffic(30, 256, 8, 65535, 0);
    test_random_traffic(15, 1, 1, 0, 65535);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(70, 511, 15, 300, 100);
    test_random_traffic(70, 3, 5, 40, $urandom_range(2000));

    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("most_fractional_assignment_select regression: pass");
    end else begin
      $display("most_fractional_assignment_select regression: fail");
    end
    $finish;
  end

endmodule
